FILE: src/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg
// Types and constants of the varint frame deframer.
// ----------------------------------------------------------------------------
package vfd_pkg;

  localparam int unsigned VARINT_MAX_BYTES = 5;
  localparam int unsigned VBYTES_W         = $clog2(VARINT_MAX_BYTES + 1);
  localparam logic [VBYTES_W-1:0] VARINT_LAST = VBYTES_W'(VARINT_MAX_BYTES - 1);

  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [15:0] ADLER_INIT = 16'd1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 136;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MESSAGE_BYTES = 2'd0,
    CFG_MIN_ACK_ID        = 2'd1,
    CFG_MAX_ACK_ID        = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SEQ      = 3'd0,
    PH_SIZE     = 3'd1,
    PH_OPCODE   = 3'd2,
    PH_BODY     = 3'd3,
    PH_ACK      = 3'd4,
    PH_ACKCOUNT = 3'd5,
    PH_ACKLIST  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_CONSUMED = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_MSG_OK   = 3'd2,
    EV_EMPTY    = 3'd3,
    EV_ACK      = 3'd4,
    EV_ERROR    = 3'd5,
    EV_HALTED   = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    ERR_VARINT_LONG = 3'd0,
    ERR_SIZE_LARGE  = 3'd1,
    ERR_CHECKSUM    = 3'd2,
    ERR_ACK_RANGE   = 3'd3,
    ERR_ACK_ZERO    = 3'd4
  } err_e;

  typedef struct packed {
    err_e        error_kind;
    logic [31:0] acked_id;
    logic [23:0] message_length;
    logic [31:0] message_sequence;
    logic [31:0] message_opcode;
    logic [7:0]  payload_byte;
    event_e      event_res;
  } result_t;

endpackage

FILE: src/varint_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// varint_frame_deframer_unit
// Receive deframer: varint headers, acks, payload and Adler sum check.
// ----------------------------------------------------------------------------
// One received byte per transaction in, one result per byte out. A byte sits
// in an input register, is decoded against the frame state combinationally and
// lands in a result register, so the unit sustains one byte per clock while
// results are taken; s_axis_tready drops only while both registers are
// full and the result is not taken. Any error halts decoding until reset.
// Configuration writes take effect at once and are meant for idle periods.
module varint_frame_deframer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // rx_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // event_res[2:0], payload_byte[10:3], message_opcode[42:11],
  // message_sequence[74:43], message_length[98:75], acked_id[130:99],
  // error_kind[133:131], zero fill[135:134]
  output logic [vfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [vfd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [vfd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  logic [23:0] max_msg_q;
  logic [31:0] min_ack_q, max_ack_q;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  vfd_pkg::result_t res_q, res_d;

  vfd_pkg::phase_e                phase_q, phase_d;
  logic [31:0]                    vval_q, vval_d;
  logic [vfd_pkg::VBYTES_W-1:0]   vbytes_q, vbytes_d;
  logic [31:0]                    seq_q, seq_d;
  logic [23:0]                    size_q, size_d;
  logic [31:0]                    opc_q, opc_d;
  logic [24:0]                    left_q, left_d;
  logic [31:0]                    acks_q, acks_d;
  logic [15:0]                    adler_q, adler_d;
  logic [7:0]                     chk_hi_q, chk_hi_d;
  logic                           halted_q, halted_d;

  logic        advance;
  logic        cont;
  logic [31:0] placed;
  logic [31:0] vnext;
  logic [16:0] sum;
  logic        ack_ok;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q <= 24'd65536;
      min_ack_q <= 32'd2;
      max_ack_q <= 32'hffff_ffff;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vfd_pkg::CFG_MAX_MESSAGE_BYTES: max_msg_q <= cfg_wdata_i[23:0];
        vfd_pkg::CFG_MIN_ACK_ID:        min_ack_q <= cfg_wdata_i;
        vfd_pkg::CFG_MAX_ACK_ID:        max_ack_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= vfd_pkg::PH_SEQ;
      vval_q   <= '0;
      vbytes_q <= '0;
      seq_q    <= '0;
      size_q   <= '0;
      opc_q    <= '0;
      left_q   <= '0;
      acks_q   <= '0;
      adler_q  <= vfd_pkg::ADLER_INIT;
      chk_hi_q <= '0;
      halted_q <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      vval_q   <= vval_d;
      vbytes_q <= vbytes_d;
      seq_q    <= seq_d;
      size_q   <= size_d;
      opc_q    <= opc_d;
      left_q   <= left_d;
      acks_q   <= acks_d;
      adler_q  <= adler_d;
      chk_hi_q <= chk_hi_d;
      halted_q <= halted_d;
    end
  end

  assign cont = in_byte_q[7];

  always_comb begin
    unique case (vbytes_q)
      3'd0:    placed = {25'd0, in_byte_q[6:0]};
      3'd1:    placed = {18'd0, in_byte_q[6:0], 7'd0};
      3'd2:    placed = {11'd0, in_byte_q[6:0], 14'd0};
      3'd3:    placed = {4'd0, in_byte_q[6:0], 21'd0};
      3'd4:    placed = {in_byte_q[3:0], 28'd0};
      default: placed = '0;
    endcase
  end

  assign vnext  = vval_q | placed;
  assign ack_ok = (vnext >= min_ack_q) && (vnext <= max_ack_q);
  assign sum    = {1'b0, adler_q} + {9'd0, in_byte_q};

  always_comb begin
    phase_d  = phase_q;
    vval_d   = vval_q;
    vbytes_d = vbytes_q;
    seq_d    = seq_q;
    size_d   = size_q;
    opc_d    = opc_q;
    left_d   = left_q;
    acks_d   = acks_q;
    adler_d  = adler_q;
    chk_hi_d = chk_hi_q;
    halted_d = halted_q;
    res_d    = '0;
    res_d.event_res  = vfd_pkg::EV_CONSUMED;
    res_d.error_kind = vfd_pkg::ERR_VARINT_LONG;

    if (halted_q) begin
      res_d.event_res = vfd_pkg::EV_HALTED;
    end else if (phase_q == vfd_pkg::PH_BODY) begin
      if (left_q > 25'd2) begin
        adler_d = (sum >= vfd_pkg::ADLER_MOD) ? 16'(sum - vfd_pkg::ADLER_MOD) : sum[15:0];
        res_d.event_res    = vfd_pkg::EV_PAYLOAD;
        res_d.payload_byte = in_byte_q;
        left_d = left_q - 25'd1;
      end else if (left_q == 25'd2) begin
        chk_hi_d = in_byte_q;
        left_d   = 25'd1;
      end else begin
        left_d  = '0;
        phase_d = vfd_pkg::PH_SEQ;
        if ({chk_hi_q, in_byte_q} == adler_q) begin
          res_d.event_res      = vfd_pkg::EV_MSG_OK;
          res_d.message_opcode = opc_q;
          res_d.message_length = size_q;
        end else begin
          res_d.event_res  = vfd_pkg::EV_ERROR;
          res_d.error_kind = vfd_pkg::ERR_CHECKSUM;
        end
      end
    end else if (cont && vbytes_q == vfd_pkg::VARINT_LAST) begin
      vval_d   = '0;
      vbytes_d = '0;
      res_d.event_res  = vfd_pkg::EV_ERROR;
      res_d.error_kind = vfd_pkg::ERR_VARINT_LONG;
    end else if (cont) begin
      vval_d   = vnext;
      vbytes_d = vbytes_q + 3'd1;
    end else begin
      vval_d   = '0;
      vbytes_d = '0;
      unique case (phase_q)
        vfd_pkg::PH_SEQ: begin
          seq_d = vnext;
          if (vnext == 32'd0) begin
            phase_d = vfd_pkg::PH_ACK;
          end else if (vnext == 32'd1) begin
            phase_d = vfd_pkg::PH_ACKCOUNT;
          end else begin
            phase_d = vfd_pkg::PH_SIZE;
          end
        end
        vfd_pkg::PH_SIZE: begin
          if (vnext > {8'd0, max_msg_q}) begin
            res_d.event_res  = vfd_pkg::EV_ERROR;
            res_d.error_kind = vfd_pkg::ERR_SIZE_LARGE;
          end else begin
            size_d  = vnext[23:0];
            phase_d = vfd_pkg::PH_OPCODE;
          end
        end
        vfd_pkg::PH_OPCODE: begin
          opc_d = vnext;
          if (size_q == 24'd0) begin
            res_d.event_res      = vfd_pkg::EV_EMPTY;
            res_d.message_opcode = vnext;
            phase_d = vfd_pkg::PH_SEQ;
          end else if (({1'b0, size_q} + 25'd2) > {1'b0, max_msg_q}) begin
            res_d.event_res  = vfd_pkg::EV_ERROR;
            res_d.error_kind = vfd_pkg::ERR_SIZE_LARGE;
          end else begin
            left_d  = {1'b0, size_q} + 25'd2;
            adler_d = vfd_pkg::ADLER_INIT;
            phase_d = vfd_pkg::PH_BODY;
          end
        end
        vfd_pkg::PH_ACK: begin
          if (ack_ok) begin
            res_d.event_res = vfd_pkg::EV_ACK;
            res_d.acked_id  = vnext;
            phase_d = vfd_pkg::PH_SEQ;
          end else begin
            res_d.event_res  = vfd_pkg::EV_ERROR;
            res_d.error_kind = vfd_pkg::ERR_ACK_RANGE;
          end
        end
        vfd_pkg::PH_ACKCOUNT: begin
          if (vnext == 32'd0) begin
            res_d.event_res  = vfd_pkg::EV_ERROR;
            res_d.error_kind = vfd_pkg::ERR_ACK_ZERO;
          end else begin
            acks_d  = vnext;
            phase_d = vfd_pkg::PH_ACKLIST;
          end
        end
        vfd_pkg::PH_ACKLIST: begin
          if (ack_ok) begin
            res_d.event_res = vfd_pkg::EV_ACK;
            res_d.acked_id  = vnext;
            acks_d = acks_q - 32'd1;
            if (acks_q == 32'd1) begin
              phase_d = vfd_pkg::PH_SEQ;
            end
          end else begin
            res_d.event_res  = vfd_pkg::EV_ERROR;
            res_d.error_kind = vfd_pkg::ERR_ACK_RANGE;
          end
        end
        default: ;
      endcase
    end

    if (res_d.event_res == vfd_pkg::EV_ERROR) begin
      halted_d = 1'b1;
    end
    res_d.message_sequence = seq_d;
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && halted_q |=> res_q.event_res == vfd_pkg::EV_HALTED && halted_q)
    else $error("halted unit produced a non-halted result");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.event_res == vfd_pkg::EV_ERROR |=> halted_q)
    else $error("error did not halt the unit");

  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == vfd_pkg::PH_BODY |-> left_q != 25'd0)
    else $error("body phase with no bytes left");

  a_adler_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, adler_q} < vfd_pkg::ADLER_MOD)
    else $error("running sum out of modular range");

  a_varint_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vbytes_q <= vfd_pkg::VARINT_LAST)
    else $error("varint byte count overrun");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(res_q) && out_valid_q)
    else $error("stalled result changed");

endmodule

FILE: sim/varint_frame_deframer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// varint_frame_deframer_unit_test
// Self-checking bench for the varint frame deframer.
// ----------------------------------------------------------------------------
// Streams well-formed frames (acks, ack lists, empty and payload messages)
// with random content through the deframer under several register settings.
// Both sides idle at random, and once the sink holds off long enough to
// back up the input. Every result is checked against an in-bench decoder.
// One closing fault halts the unit, and the trailing bytes must report halt.
module varint_frame_deframer_unit_test;

  localparam int unsigned WATCHDOG_CYCLES = 3000;
  localparam int unsigned PRESS_CYCLES    = 300;
  localparam int unsigned PHASE_BYTES     = 100;
  localparam int unsigned CLOSE_ACK_FLIP  = 5;
  localparam int unsigned RES_W           = $bits(vfd_pkg::result_t);
  localparam logic [vfd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [8*28-1:0] WARMUP_BYTES = {
    8'h80, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f,
    8'h01, 8'h01, 8'h80, 8'h01,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h00, 8'h00,
    8'h02, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'hff, 8'h01, 8'h00
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;  // rx_byte
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // event_res, payload_byte, message_opcode, message_sequence,
  // message_length, acked_id, error_kind, zero fill
  logic [vfd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_we_i      = 1'b0;
  logic [vfd_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [vfd_pkg::CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // decoder state and register copies
  vfd_pkg::phase_e ph          = vfd_pkg::PH_SEQ;
  logic [31:0]     vint_acc    = '0;
  logic [2:0]      vint_cnt    = '0;
  logic [31:0]     seq_id      = '0;
  logic [23:0]     msg_size    = '0;
  logic [31:0]     opcode_id   = '0;
  logic [24:0]     body_left   = '0;
  logic [31:0]     acks_remain = '0;
  logic [15:0]     adler_a     = vfd_pkg::ADLER_INIT;
  logic [7:0]      csum_hi     = '0;
  bit              halted_q    = 1'b0;
  logic [23:0]     lim_msg     = 24'd65536;
  logic [31:0]     lim_ack_lo  = 32'd2;
  logic [31:0]     lim_ack_hi  = 32'hffffffff;

  logic [7:0]       rx_bytes_q[$];
  vfd_pkg::result_t frame_events_q[$];
  int unsigned bytes_built  = 0;
  int unsigned bytes_in     = 0;
  int unsigned mismatches   = 0;
  int unsigned ev_tally[8];
  int unsigned close_kind   = 0;
  int unsigned src_wait     = 0;
  int unsigned sink_wait    = 0;
  int unsigned quiet_cycles = 0;
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;
  bit          press_req    = 1'b0;
  bit          press_taken  = 1'b0;

  varint_frame_deframer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit ack_ok(logic [31:0] id);
    return id >= lim_ack_lo && id <= lim_ack_hi;
  endfunction

  function automatic vfd_pkg::result_t deframe_step(logic [7:0] rx);
    vfd_pkg::result_t r;
    logic [31:0]      val;
    logic [31:0]      chunk;
    logic [16:0]      sum;
    bit               done;
    r    = '0;
    val  = '0;
    done = 1'b0;
    if (halted_q) begin
      r.event_res = vfd_pkg::EV_HALTED;
    end else if (ph == vfd_pkg::PH_BODY) begin
      if (body_left > 25'd2) begin
        sum = {1'b0, adler_a} + {9'd0, rx};
        if (sum >= vfd_pkg::ADLER_MOD) begin
          sum = sum - vfd_pkg::ADLER_MOD;
        end
        adler_a        = sum[15:0];
        r.event_res    = vfd_pkg::EV_PAYLOAD;
        r.payload_byte = rx;
        body_left      = body_left - 25'd1;
      end else if (body_left == 25'd2) begin
        csum_hi   = rx;
        body_left = 25'd1;
      end else begin
        body_left = '0;
        ph        = vfd_pkg::PH_SEQ;
        if ({csum_hi, rx} == adler_a) begin
          r.event_res      = vfd_pkg::EV_MSG_OK;
          r.message_opcode = opcode_id;
          r.message_length = msg_size;
        end else begin
          r.event_res  = vfd_pkg::EV_ERROR;
          r.error_kind = vfd_pkg::ERR_CHECKSUM;
        end
      end
    end else begin
      if (rx[7] && vint_cnt >= vfd_pkg::VARINT_LAST) begin
        vint_acc     = '0;
        vint_cnt     = '0;
        r.event_res  = vfd_pkg::EV_ERROR;
        r.error_kind = vfd_pkg::ERR_VARINT_LONG;
      end else begin
        chunk    = {25'd0, rx[6:0]} << (7 * vint_cnt);
        vint_acc = vint_acc + chunk;
        if (rx[7]) begin
          vint_cnt = vint_cnt + 3'd1;
        end else begin
          val      = vint_acc;
          vint_acc = '0;
          vint_cnt = '0;
          done     = 1'b1;
        end
      end
      if (done) begin
        case (ph)
          vfd_pkg::PH_SEQ: begin
            seq_id = val;
            ph = (val == 0) ? vfd_pkg::PH_ACK :
                 (val == 1) ? vfd_pkg::PH_ACKCOUNT : vfd_pkg::PH_SIZE;
          end
          vfd_pkg::PH_SIZE: begin
            if (val > {8'd0, lim_msg}) begin
              r.event_res  = vfd_pkg::EV_ERROR;
              r.error_kind = vfd_pkg::ERR_SIZE_LARGE;
            end else begin
              msg_size = val[23:0];
              ph       = vfd_pkg::PH_OPCODE;
            end
          end
          vfd_pkg::PH_OPCODE: begin
            opcode_id = val;
            if (msg_size == 0) begin
              r.event_res      = vfd_pkg::EV_EMPTY;
              r.message_opcode = val;
              ph               = vfd_pkg::PH_SEQ;
            end else if ({1'b0, msg_size} + 25'd2 > {1'b0, lim_msg}) begin
              r.event_res  = vfd_pkg::EV_ERROR;
              r.error_kind = vfd_pkg::ERR_SIZE_LARGE;
            end else begin
              body_left = {1'b0, msg_size} + 25'd2;
              adler_a   = vfd_pkg::ADLER_INIT;
              ph        = vfd_pkg::PH_BODY;
            end
          end
          vfd_pkg::PH_ACK: begin
            if (ack_ok(val)) begin
              r.event_res = vfd_pkg::EV_ACK;
              r.acked_id  = val;
              ph          = vfd_pkg::PH_SEQ;
            end else begin
              r.event_res  = vfd_pkg::EV_ERROR;
              r.error_kind = vfd_pkg::ERR_ACK_RANGE;
            end
          end
          vfd_pkg::PH_ACKCOUNT: begin
            if (val == 0) begin
              r.event_res  = vfd_pkg::EV_ERROR;
              r.error_kind = vfd_pkg::ERR_ACK_ZERO;
            end else begin
              acks_remain = val;
              ph          = vfd_pkg::PH_ACKLIST;
            end
          end
          default: begin
            if (ack_ok(val)) begin
              r.event_res = vfd_pkg::EV_ACK;
              r.acked_id  = val;
              acks_remain = acks_remain - 32'd1;
              if (acks_remain == 0) begin
                ph = vfd_pkg::PH_SEQ;
              end
            end else begin
              r.event_res  = vfd_pkg::EV_ERROR;
              r.error_kind = vfd_pkg::ERR_ACK_RANGE;
            end
          end
        endcase
      end
    end
    if (r.event_res == vfd_pkg::EV_ERROR) begin
      halted_q = 1'b1;
    end
    r.message_sequence = seq_id;
    return r;
  endfunction

  function automatic int unsigned draw_gap(bit on);
    int unsigned r;
    if (!on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_built++;
  endfunction

  // encode little-endian base 128, sometimes padded, with junk above bit 31
  function automatic void put_varint(logic [31:0] v);
    int unsigned n;
    int unsigned i;
    logic [7:0]  b;
    n = 1;
    while (n < vfd_pkg::VARINT_MAX_BYTES && (v >> (7 * n)) != 0) begin
      n++;
    end
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(vfd_pkg::VARINT_MAX_BYTES, n);
    end
    for (i = 0; i < n; i++) begin
      b = {1'b0, 7'(v >> (7 * i))};
      if (i == vfd_pkg::VARINT_MAX_BYTES - 1) begin
        b[6:4] = 3'($urandom_range(0, 7));
      end
      b[7] = (i + 1 < n);
      put_byte(b);
    end
  endfunction

  function automatic logic [31:0] data_seq();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    if (v < 2) begin
      v = v + 32'd2;
    end
    return v;
  endfunction

  function automatic logic [31:0] rand_ack();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return lim_ack_lo;
    end
    if (r == 1) begin
      return lim_ack_hi;
    end
    return $urandom_range(lim_ack_hi, lim_ack_lo);
  endfunction

  function automatic int unsigned rand_size();
    int unsigned room;
    int unsigned cap;
    int unsigned r;
    room = (lim_msg >= 3) ? lim_msg - 2 : 0;
    r    = $urandom_range(0, 99);
    if (room == 0 || r < 20) begin
      return 0;
    end
    if (r < 28 && room <= 200) begin
      return room;
    end
    cap = (r >= 95) ? 200 : 24;
    if (cap > room) begin
      cap = room;
    end
    return $urandom_range(1, cap);
  endfunction

  function automatic void put_data_frame(logic [31:0] seq, int unsigned size, bit corrupt,
                                         bit all_ones);
    logic [15:0] a;
    logic [7:0]  d;
    logic [31:0] sum;
    int unsigned i;
    put_varint(seq);
    put_varint(size);
    put_varint($urandom);
    if (size == 0) begin
      return;
    end
    a = vfd_pkg::ADLER_INIT;
    for (i = 0; i < size; i++) begin
      d   = all_ones ? 8'hff : 8'($urandom_range(0, 255));
      sum = {16'd0, a} + {24'd0, d};
      if (sum >= vfd_pkg::ADLER_MOD) begin
        sum = sum - vfd_pkg::ADLER_MOD;
      end
      a = sum[15:0];
      put_byte(d);
    end
    if (corrupt) begin
      a[7:0] = a[7:0] ^ 8'($urandom_range(1, 255));
    end
    put_byte(a[15:8]);
    put_byte(a[7:0]);
  endfunction

  function automatic void build_frames(int unsigned target, bit acks_ok);
    int unsigned start;
    int unsigned k;
    int unsigned n;
    start = bytes_built;
    while (bytes_built - start < target) begin
      k = acks_ok ? $urandom_range(0, 9) : 9;
      if (k < 2) begin
        put_varint(0);
        put_varint(rand_ack());
      end else if (k < 4) begin
        n = $urandom_range(1, 4);
        put_varint(1);
        put_varint(n);
        repeat (n) put_varint(rand_ack());
      end else begin
        put_data_frame(data_seq(), rand_size(), 1'b0, 1'b0);
      end
    end
  endfunction

  task automatic write_cfg(logic [vfd_pkg::CFG_IDX_W-1:0] idx,
                           logic [vfd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      vfd_pkg::CFG_MAX_MESSAGE_BYTES: lim_msg    = data[23:0];
      vfd_pkg::CFG_MIN_ACK_ID:        lim_ack_lo = data;
      vfd_pkg::CFG_MAX_ACK_ID:        lim_ack_hi = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (rx_bytes_q.size() != 0 || s_axis_tvalid || frame_events_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [23:0] lim, logic [31:0] lo, logic [31:0] hi);
    write_cfg(vfd_pkg::CFG_MAX_MESSAGE_BYTES, {8'($urandom), lim});
    write_cfg(vfd_pkg::CFG_MIN_ACK_ID, lo);
    write_cfg(vfd_pkg::CFG_MAX_ACK_ID, hi);
  endtask

  // end with one fault, then bytes that must report halt
  task automatic close_with_fault();
    logic [23:0] lim;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] v;
    close_kind = $urandom_range(0, CLOSE_ACK_FLIP);
    lim = 24'($urandom_range(3, 60));
    lo  = $urandom_range(2, 1000);
    hi  = lo + $urandom_range(0, 1000);
    if (close_kind == CLOSE_ACK_FLIP) begin
      hi = $urandom_range(0, lo - 1);
    end
    set_limits(lim, lo, hi);
    src_idle_on  <= 1'b1;
    sink_idle_on <= 1'b1;
    build_frames(30, close_kind != CLOSE_ACK_FLIP);
    case (close_kind)
      vfd_pkg::ERR_VARINT_LONG: begin
        if ($urandom_range(0, 1) == 1) begin
          put_varint(data_seq());
        end
        repeat (vfd_pkg::VARINT_MAX_BYTES) put_byte(8'h80 | 8'($urandom_range(0, 127)));
      end
      vfd_pkg::ERR_SIZE_LARGE: begin
        put_varint(data_seq());
        if ($urandom_range(0, 1) == 1) begin
          v = {8'd0, lim} + 32'd1 + ($urandom >> $urandom_range(0, 31));
          if (v <= {8'd0, lim}) begin
            v = {8'd0, lim} + 32'd1;
          end
          put_varint(v);
        end else begin
          put_varint(lim - $urandom_range(0, 1));
        end
        put_varint($urandom);
      end
      vfd_pkg::ERR_CHECKSUM: begin
        put_data_frame(data_seq(), $urandom_range(1, lim - 2), 1'b1, 1'b0);
      end
      vfd_pkg::ERR_ACK_RANGE: begin
        if ($urandom_range(0, 1) == 1) begin
          put_varint(0);
          put_varint(($urandom_range(0, 1) == 1) ? lo - 32'd1 : hi + 32'd1);
        end else begin
          put_varint(1);
          put_varint(2);
          put_varint(rand_ack());
          put_varint(($urandom_range(0, 1) == 1) ? lo - 32'd1 : hi + 32'd1);
        end
      end
      vfd_pkg::ERR_ACK_ZERO: begin
        put_varint(1);
        put_varint(0);
      end
      default: begin
        put_varint(0);
        put_varint($urandom);
      end
    endcase
    repeat (8) put_byte(8'($urandom_range(0, 255)));
  endtask

  // driver: offer queued bytes, decode each accepted one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_events_q.push_back(deframe_step(s_axis_tdata));
        bytes_in++;
        src_wait = draw_gap(src_idle_on);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          s_axis_tdata  <= rx_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest decoded event
  always @(posedge clk_i or negedge rst_ni) begin : sink
    vfd_pkg::result_t                      want;
    vfd_pkg::result_t                      got;
    logic [vfd_pkg::OUT_DATA_W-RES_W-1:0]  fill;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got  = m_axis_tdata[RES_W-1:0];
        fill = m_axis_tdata[vfd_pkg::OUT_DATA_W-1:RES_W];
        if (frame_events_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: ev=%0d seq=%08h", got.event_res,
                     got.message_sequence);
          end
        end else begin
          want = frame_events_q.pop_front();
          ev_tally[want.event_res]++;
          if (got !== want || fill !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: want ev=%0d pay=%02h opc=%08h seq=%08h",
                       want.event_res, want.payload_byte, want.message_opcode,
                       want.message_sequence);
              $display("          want len=%0d ack=%08h err=%0d",
                       want.message_length, want.acked_id, want.error_kind);
              $display("          got  ev=%0d pay=%02h opc=%08h seq=%08h",
                       got.event_res, got.payload_byte, got.message_opcode,
                       got.message_sequence);
              $display("          got  len=%0d ack=%08h err=%0d fill=%0h",
                       got.message_length, got.acked_id, got.error_kind, fill);
            end
          end
        end
        sink_wait = draw_gap(sink_idle_on);
      end
      if (press_req && !press_taken) begin
        press_taken = 1'b1;
        sink_wait   = PRESS_CYCLES;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned i;
    logic [23:0] lim;
    logic [31:0] lo;
    logic [31:0] hi;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < 28; i++) begin
      put_byte(WARMUP_BYTES[8 * (27 - i) +: 8]);
    end
    build_frames(PHASE_BYTES, 1'b1);
    drain();
    for (p = 1; p <= 8; p++) begin
      case (p)
        1: begin
          lim = 24'hffffff;
          lo  = 32'd0;
          hi  = 32'hffffffff;
        end
        2: begin
          lim = 24'd0;
          lo  = $urandom;
          hi  = lo;
        end
        3: begin
          lim = 24'd3;
          lo  = 32'hffffffff;
          hi  = 32'hffffffff;
        end
        4: begin
          lim = 24'd400;
          lo  = 32'd2;
          hi  = 32'hfffffffe;
        end
        5: begin
          lim = 24'd2;
          lo  = 32'd0;
          hi  = 32'd0;
        end
        default: begin
          lim = ($urandom_range(0, 1) == 1) ? 24'($urandom_range(0, 80)) : 24'($urandom);
          lo  = $urandom >> $urandom_range(0, 31);
          hi  = $urandom_range(32'hffffffff, lo);
        end
      endcase
      set_limits(lim, lo, hi);
      if (p == 1) begin
        write_cfg(CFG_IDX_SPARE, $urandom);
      end
      src_idle_on  <= (p != 1) && ($urandom_range(0, 3) != 0);
      sink_idle_on <= (p != 1) && ($urandom_range(0, 3) != 0);
      if (p == 4) begin
        put_data_frame(data_seq(), 300, 1'b0, 1'b1);
      end
      if (p == 6) begin
        press_req <= 1'b1;
      end
      build_frames(PHASE_BYTES, 1'b1);
      drain();
    end
    close_with_fault();
    drain();
    repeat (10) @(posedge clk_i);
    if (frame_events_q.size() != 0) begin
      mismatches += frame_events_q.size();
      $display("%0d results never arrived", frame_events_q.size());
    end
    $display("covered %0d bytes over ten register settings: %0d payload bytes,",
             bytes_in, ev_tally[vfd_pkg::EV_PAYLOAD]);
    $display("%0d messages, %0d empty, %0d acks",
             ev_tally[vfd_pkg::EV_MSG_OK], ev_tally[vfd_pkg::EV_EMPTY],
             ev_tally[vfd_pkg::EV_ACK]);
    $display("closing fault kind %0d, %0d bytes seen while halted, %0d mismatches",
             close_kind, ev_tally[vfd_pkg::EV_HALTED], mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/vfd_pkg.sv
src/varint_frame_deframer_unit.sv
sim/varint_frame_deframer_unit_test.sv
